[rtl/core/bpc_pkg.sv]
// bpc_pkg: shared types, widths and constants for the pressure compensation core
// no dependencies
package bpc_pkg;

	localparam int unsigned DIV_STEPS = 3;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OSS   = 3'd3;

	localparam int unsigned D1_N = 27;
	localparam int unsigned D1_M = 20;
	localparam int unsigned D2_N = 33;
	localparam int unsigned D2_M = 32;

	localparam int TEMP_OFFSET = 4000;
	localparam int B4_BIAS     = 32768;
	localparam int B7_SCALE    = 50000;
	localparam logic [31:0] B7_SPLIT = 32'h8000_0000;
	localparam int PC_SQ       = 3038;
	localparam int PC_LIN_MAG  = 7357;
	localparam int PC_OFS      = 3791;
	localparam int Q_SAT       = 2 ** 21;
	localparam int P_MAX       = 1048575;

	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} cal_t;

	typedef struct packed {
		logic [18:0] x1;
		logic        neg;
		logic        err;
		logic [18:0] up;
	} d1_side_t;

	typedef struct packed {
		logic [15:0] t;
		logic        err;
		logic        dbl;
	} d2_side_t;

endpackage

[rtl/core/bpc_div.sv]
// bpc_div: pipelined restoring unsigned divider with a sideband that travels along;
// K quotient bits per stage; no package dependencies
module bpc_div #(
	parameter int unsigned N  = 27,
	parameter int unsigned M  = 20,
	parameter int unsigned K  = 3,
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [N-1:0]  dividend,
	input  logic [M-1:0]  divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [N-1:0]  quotient,
	output logic [SW-1:0] side_out
);

	localparam int unsigned NS = (N + K - 1) / K;

	logic          v_s   [NS];
	logic [M-1:0]  rem_s [NS];
	logic [N-1:0]  dq_s  [NS];
	logic [M-1:0]  dvs_s [NS];
	logic [SW-1:0] sd_s  [NS];
	logic [NS:0]   en;

	assign en[NS]   = out_ready;
	assign in_ready = en[0];

	for (genvar i = 0; i < NS; i++) begin : g_stg
		logic          v_in;
		logic [M-1:0]  rem_in;
		logic [N-1:0]  dq_in;
		logic [M-1:0]  d_in;
		logic [SW-1:0] sd_in;
		logic [M-1:0]  rem_nx;
		logic [N-1:0]  dq_nx;

		if (i == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = '0;
			assign dq_in  = dividend;
			assign d_in   = divisor;
			assign sd_in  = side_in;
		end else begin : g_next
			assign v_in   = v_s[i-1];
			assign rem_in = rem_s[i-1];
			assign dq_in  = dq_s[i-1];
			assign d_in   = dvs_s[i-1];
			assign sd_in  = sd_s[i-1];
		end

		always_comb begin
			logic [M:0] r2;
			r2     = '0;
			rem_nx = rem_in;
			dq_nx  = dq_in;
			for (int j = 0; j < int'(K); j++) begin
				if (int'(i * K) + j < int'(N)) begin
					r2 = {rem_nx, dq_nx[N-1]};
					if (r2 >= {1'b0, d_in}) begin
						r2    = r2 - {1'b0, d_in};
						dq_nx = {dq_nx[N-2:0], 1'b1};
					end else begin
						dq_nx = {dq_nx[N-2:0], 1'b0};
					end
					rem_nx = r2[M-1:0];
				end
			end
		end

		assign en[i] = !v_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= rem_nx;
				dq_s[i]  <= dq_nx;
				dvs_s[i] <= d_in;
				sd_s[i]  <= sd_in;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign quotient  = dq_s[NS-1];
	assign side_out  = sd_s[NS-1];

endmodule

[rtl/core/bpc_front.sv]
// bpc_front: first temperature term and operand setup for the temperature division
// depends on bpc_pkg
module bpc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [15:0]                raw_temp,
	input  logic [18:0]                raw_pressure,
	input  bpc_pkg::cal_t              cal,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bpc_pkg::D1_N-1:0]   dividend,
	output logic [bpc_pkg::D1_M-1:0]   divisor,
	output bpc_pkg::d1_side_t          side
);

	logic en1, en2;
	logic v_s1, v_s2;

	logic signed [16:0] dlt, ac5x;
	logic signed [33:0] prod;
	logic signed [33:0] prod_s1;
	logic [18:0]        up_s1;

	logic signed [18:0] x1;
	logic signed [19:0] dv;
	logic [19:0]        dv_mag;
	logic [15:0]        mc_mag;

	logic [bpc_pkg::D1_N-1:0] dvd_s2;
	logic [bpc_pkg::D1_M-1:0] dvs_s2;
	bpc_pkg::d1_side_t        side_s2;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign dlt  = $signed({1'b0, raw_temp} - {1'b0, cal.ac6});
	assign ac5x = $signed({1'b0, cal.ac5});
	assign prod = dlt * ac5x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= prod;
			up_s1   <= raw_pressure;
		end
	end

	assign x1     = prod_s1[33:15];
	assign dv     = 20'(x1) + 20'($signed(cal.md));
	assign dv_mag = dv[19] ? 20'(-dv) : 20'(dv);
	assign mc_mag = cal.mc[15] ? 16'(-$signed(cal.mc)) : cal.mc;

	always_ff @(posedge clk) begin
		if (en2) begin
			dvd_s2      <= {mc_mag, 11'b0};
			dvs_s2      <= dv_mag;
			side_s2.x1  <= x1;
			side_s2.neg <= dv[19] ^ cal.mc[15];
			side_s2.err <= (dv == '0);
			side_s2.up  <= up_s1;
		end
	end

	assign out_valid = v_s2;
	assign dividend  = dvd_s2;
	assign divisor   = dvs_s2;
	assign side      = side_s2;

endmodule

[rtl/core/bpc_terms.sv]
// bpc_terms: temperature result and the b3, b4, b7 pressure terms over six stages
// depends on bpc_pkg; feeds the pressure division
module bpc_terms (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bpc_pkg::D1_N-1:0]   quotient,
	input  bpc_pkg::d1_side_t          side_in,
	input  bpc_pkg::cal_t              cal,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bpc_pkg::D2_N-1:0]   dividend,
	output logic [bpc_pkg::D2_M-1:0]   divisor,
	output bpc_pkg::d2_side_t          side_out
);

	logic [6:1] v;
	logic [7:1] en;

	// stage 1
	logic [27:0]        qq;
	logic signed [27:0] qs;
	logic signed [28:0] b5;
	logic [28:0]        b5_s1;
	logic               err_s1;
	logic [18:0]        up_s1;

	// stage 2
	logic signed [29:0] b5x, b6, tsum;
	logic signed [25:0] tt;
	logic [15:0]        tc;
	logic signed [59:0] sqf;
	logic signed [45:0] m2, m3;
	logic signed [59:0] sqf_s2;
	logic signed [45:0] m2_s2, m3_s2;
	logic [15:0]        t_s2;
	logic               err_s2;
	logic [18:0]        up_s2;

	// stage 3
	logic [47:0]        sq;
	logic signed [40:0] pp2l, pp2h, pp1l, pp1h;
	logic signed [40:0] pp2l_s3, pp2h_s3, pp1l_s3, pp1h_s3;
	logic [34:0]        x2a_s3;
	logic [32:0]        x1c_s3;
	logic [15:0]        t_s3;
	logic               err_s3;
	logic [18:0]        up_s3;

	// stage 4
	logic signed [63:0] b2sq, b1sq;
	logic [52:0]        x1b_s4;
	logic [47:0]        x2b_s4;
	logic [34:0]        x2a_s4;
	logic [32:0]        x1c_s4;
	logic [15:0]        t_s4;
	logic               err_s4;
	logic [18:0]        up_s4;

	// stage 5
	logic signed [63:0] s3, sh, b3r, x3r;
	logic [31:0]        b3l_s5, x3u_s5;
	logic [15:0]        t_s5;
	logic               err_s5;
	logic [18:0]        up_s5;

	// stage 6
	logic [47:0]        b4p, b7p;
	logic [31:0]        diff;
	logic [15:0]        scale;
	logic [31:0]        b4_s6, b7_s6;
	logic [15:0]        t_s6;
	logic               err_s6;

	assign en[7] = out_ready;
	for (genvar i = 1; i <= 6; i++) begin : g_en
		assign en[i] = !v[i] || en[i+1];
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			if (en[2]) v[2] <= v[1];
			if (en[3]) v[3] <= v[2];
			if (en[4]) v[4] <= v[3];
			if (en[5]) v[5] <= v[4];
			if (en[6]) v[6] <= v[5];
		end
	end

	// signed temperature quotient and b5
	assign qq = {1'b0, quotient};
	assign qs = side_in.neg ? $signed(-qq) : $signed(qq);
	assign b5 = 29'($signed(side_in.x1)) + 29'(qs);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			b5_s1  <= b5;
			err_s1 <= side_in.err;
			up_s1  <= side_in.up;
		end
	end

	// b6, its square, linear products, temperature result
	assign b5x  = 30'($signed(b5_s1));
	assign b6   = b5x - 30'(bpc_pkg::TEMP_OFFSET);
	assign sqf  = b6 * b6;
	assign m2   = $signed(cal.ac2) * b6;
	assign m3   = $signed(cal.ac3) * b6;
	assign tsum = b5x + 30'sd8;
	assign tt   = tsum[29:4];

	always_comb begin
		if (tt > 26'sd32767) begin
			tc = 16'h7FFF;
		end else if (tt < -26'sd32768) begin
			tc = 16'h8000;
		end else begin
			tc = tt[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sqf_s2 <= sqf;
			m2_s2  <= m2;
			m3_s2  <= m3;
			t_s2   <= tc;
			err_s2 <= err_s1;
			up_s2  <= up_s1;
		end
	end

	// partial products of b2 * sq and b1 * sq
	assign sq   = sqf_s2[59:12];
	assign pp2l = $signed(cal.b2) * $signed({1'b0, sq[23:0]});
	assign pp2h = $signed(cal.b2) * $signed({1'b0, sq[47:24]});
	assign pp1l = $signed(cal.b1) * $signed({1'b0, sq[23:0]});
	assign pp1h = $signed(cal.b1) * $signed({1'b0, sq[47:24]});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pp2l_s3 <= pp2l;
			pp2h_s3 <= pp2h;
			pp1l_s3 <= pp1l;
			pp1h_s3 <= pp1h;
			x2a_s3  <= m2_s2[45:11];
			x1c_s3  <= m3_s2[45:13];
			t_s3    <= t_s2;
			err_s3  <= err_s2;
			up_s3   <= up_s2;
		end
	end

	assign b2sq = (64'(pp2h_s3) <<< 24) + 64'(pp2l_s3);
	assign b1sq = (64'(pp1h_s3) <<< 24) + 64'(pp1l_s3);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			x1b_s4 <= b2sq[63:11];
			x2b_s4 <= b1sq[63:16];
			x2a_s4 <= x2a_s3;
			x1c_s4 <= x1c_s3;
			t_s4   <= t_s3;
			err_s4 <= err_s3;
			up_s4  <= up_s3;
		end
	end

	// b3 and x3, low words only
	assign s3  = (64'($signed(cal.ac1)) <<< 2) + 64'($signed(x1b_s4))
		+ 64'($signed(x2a_s4));
	assign sh  = s3 <<< cal.oss;
	assign b3r = sh + 64'sd2;
	assign x3r = 64'($signed(x1c_s4)) + 64'($signed(x2b_s4)) + 64'sd2;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			b3l_s5 <= b3r[33:2];
			x3u_s5 <= x3r[33:2] + 32'(bpc_pkg::B4_BIAS);
			t_s5   <= t_s4;
			err_s5 <= err_s4;
			up_s5  <= up_s4;
		end
	end

	// b4 and b7
	assign b4p   = 48'(cal.ac4) * 48'(x3u_s5);
	assign diff  = 32'(up_s5) - b3l_s5;
	assign scale = 16'(bpc_pkg::B7_SCALE) >> cal.oss;
	assign b7p   = 48'(diff) * 48'(scale);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			b4_s6  <= b4p[46:15];
			b7_s6  <= b7p[31:0];
			t_s6   <= t_s5;
			err_s6 <= err_s5;
		end
	end

	assign out_valid    = v[6];
	assign divisor      = b4_s6;
	assign dividend     = (b7_s6 < bpc_pkg::B7_SPLIT) ? {b7_s6, 1'b0} : {1'b0, b7_s6};
	assign side_out.t   = t_s6;
	assign side_out.err = err_s6 || (b4_s6 == '0);
	assign side_out.dbl = (b7_s6 >= bpc_pkg::B7_SPLIT);

endmodule

[rtl/core/bpc_post.sv]
// bpc_post: pressure polynomial correction, saturation and output register
// depends on bpc_pkg
module bpc_post (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bpc_pkg::D2_N-1:0]   quotient,
	input  bpc_pkg::d2_side_t          side_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [15:0]                temp_tenths,
	output logic [19:0]                pressure_pa,
	output logic                       error_code
);

	logic [4:1] v;
	logic [5:1] en;

	logic [33:0] qf;
	logic [21:0] qsat;
	logic [21:0] q_s1, q_s2, q_s3;
	logic [15:0] t_s1, t_s2, t_s3, t_s4;
	logic        err_s1, err_s2, err_s3, err_s4;

	logic [13:0] a;
	logic [27:0] a2, a2_s2;
	logic [35:0] lin, lin_s2;

	logic [39:0]        sqt;
	logic signed [36:0] nl;
	logic [23:0]        x1_s3;
	logic [20:0]        x2_s3;

	logic signed [26:0] corr, pf;
	logic [19:0]        pc;
	logic [19:0]        p_s4;

	assign en[5] = out_ready;
	for (genvar i = 1; i <= 4; i++) begin : g_en
		assign en[i] = !v[i] || en[i+1];
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= in_valid;
			if (en[2]) v[2] <= v[1];
			if (en[3]) v[3] <= v[2];
			if (en[4]) v[4] <= v[3];
		end
	end

	// any quotient past the clamp threshold ends above full scale
	assign qf   = side_in.dbl ? {quotient, 1'b0} : {1'b0, quotient};
	assign qsat = (qf >= 34'(bpc_pkg::Q_SAT)) ? 22'(bpc_pkg::Q_SAT) : qf[21:0];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s1   <= qsat;
			t_s1   <= side_in.t;
			err_s1 <= side_in.err;
		end
	end

	assign a   = q_s1[21:8];
	assign a2  = 28'(a) * 28'(a);
	assign lin = 36'(q_s1) * 36'(bpc_pkg::PC_LIN_MAG);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a2_s2  <= a2;
			lin_s2 <= lin;
			q_s2   <= q_s1;
			t_s2   <= t_s1;
			err_s2 <= err_s1;
		end
	end

	assign sqt = 40'(a2_s2) * 40'(bpc_pkg::PC_SQ);
	assign nl  = -$signed({1'b0, lin_s2});

	always_ff @(posedge clk) begin
		if (en[3]) begin
			x1_s3  <= sqt[39:16];
			x2_s3  <= nl[36:16];
			q_s3   <= q_s2;
			t_s3   <= t_s2;
			err_s3 <= err_s2;
		end
	end

	assign corr = 27'($signed({1'b0, x1_s3})) + 27'($signed(x2_s3))
		+ 27'(bpc_pkg::PC_OFS);
	assign pf   = 27'($signed({1'b0, q_s3})) + 27'($signed(corr[26:4]));

	always_comb begin
		if (pf < 27'sd0) begin
			pc = '0;
		end else if (pf > 27'(bpc_pkg::P_MAX)) begin
			pc = 20'(bpc_pkg::P_MAX);
		end else begin
			pc = pf[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s4   <= err_s3 ? '0 : t_s3;
			p_s4   <= err_s3 ? '0 : pc;
			err_s4 <= err_s3;
		end
	end

	assign out_valid   = v[4];
	assign temp_tenths = t_s4;
	assign pressure_pa = p_s4;
	assign error_code  = err_s4;

endmodule

[rtl/core/barometric_pressure_compensation.sv]
// barometric_pressure_compensation: top level, calibration registers and pipeline
// depends on bpc_pkg, bpc_front, bpc_div, bpc_terms, bpc_post
//
// channel  | handshake           | payload
// in       | in_valid/in_ready   | raw_temp, raw_pressure
// out      | out_valid/out_ready | temp_tenths, pressure_pa, error_code
// cfg      | cfg_we              | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ready stays high;
// the two pipelined dividers retire DIV_STEPS quotient bits per stage
// reset clears every valid bit and every calibration register
// each stage holds while the one after it is full and stalled, so bubbles close up
module barometric_pressure_compensation #(
	parameter int unsigned DIV_STEPS = bpc_pkg::DIV_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      raw_temp,
	input  logic [18:0]                      raw_pressure,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      temp_tenths,
	output logic [19:0]                      pressure_pa,
	output logic                             error_code,
	input  logic                             cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	bpc_pkg::cal_t cal;

	logic                       f_valid, f_ready;
	logic [bpc_pkg::D1_N-1:0]   f_dvd;
	logic [bpc_pkg::D1_M-1:0]   f_dvs;
	bpc_pkg::d1_side_t          f_side;

	logic                       d1_valid, d1_ready;
	logic [bpc_pkg::D1_N-1:0]   d1_quo;
	bpc_pkg::d1_side_t          d1_side;

	logic                       t_valid, t_ready;
	logic [bpc_pkg::D2_N-1:0]   t_dvd;
	logic [bpc_pkg::D2_M-1:0]   t_dvs;
	bpc_pkg::d2_side_t          t_side;

	logic                       d2_valid, d2_ready;
	logic [bpc_pkg::D2_N-1:0]   d2_quo;
	bpc_pkg::d2_side_t          d2_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::REG_CAL_A: cal_a_q <= cfg_data;
				bpc_pkg::REG_CAL_B: cal_b_q <= cfg_data;
				bpc_pkg::REG_CAL_C: cal_c_q <= cfg_data[31:0];
				bpc_pkg::REG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.ac1 = cal_a_q[63:48];
		cal.ac2 = cal_a_q[47:32];
		cal.ac3 = cal_a_q[31:16];
		cal.ac4 = cal_a_q[15:0];
		cal.ac5 = cal_b_q[63:48];
		cal.ac6 = cal_b_q[47:32];
		cal.b1  = cal_b_q[31:16];
		cal.b2  = cal_b_q[15:0];
		cal.mc  = cal_c_q[31:16];
		cal.md  = cal_c_q[15:0];
		cal.oss = oss_q;
	end

	bpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_temp     (raw_temp),
		.raw_pressure (raw_pressure),
		.cal          (cal),
		.out_valid    (f_valid),
		.out_ready    (f_ready),
		.dividend     (f_dvd),
		.divisor      (f_dvs),
		.side         (f_side)
	);

	bpc_div #(
		.N  (bpc_pkg::D1_N),
		.M  (bpc_pkg::D1_M),
		.K  (DIV_STEPS),
		.SW ($bits(bpc_pkg::d1_side_t))
	) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.dividend  (f_dvd),
		.divisor   (f_dvs),
		.side_in   (f_side),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.quotient  (d1_quo),
		.side_out  (d1_side)
	);

	bpc_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.quotient  (d1_quo),
		.side_in   (d1_side),
		.cal       (cal),
		.out_valid (t_valid),
		.out_ready (t_ready),
		.dividend  (t_dvd),
		.divisor   (t_dvs),
		.side_out  (t_side)
	);

	bpc_div #(
		.N  (bpc_pkg::D2_N),
		.M  (bpc_pkg::D2_M),
		.K  (DIV_STEPS),
		.SW ($bits(bpc_pkg::d2_side_t))
	) u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_valid),
		.in_ready  (t_ready),
		.dividend  (t_dvd),
		.divisor   (t_dvs),
		.side_in   (t_side),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.quotient  (d2_quo),
		.side_out  (d2_side)
	);

	bpc_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d2_valid),
		.in_ready    (d2_ready),
		.quotient    (d2_quo),
		.side_in     (d2_side),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.temp_tenths (temp_tenths),
		.pressure_pa (pressure_pa),
		.error_code  (error_code)
	);

	// an error transaction carries zero results
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code |-> temp_tenths == '0 && pressure_pa == '0)
		else $error("error transaction with nonzero result");

	// input backpressure only when the whole pipeline is full behind a stalled output
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a stalled pressure divider output implies the tail is stalled too
	a_div_stall: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid && !d2_ready |-> out_valid && !out_ready)
		else $error("divider held without output stall");

endmodule
